FILE: rtl/bap_pkg.sv
// ----------------------------------------------------------------------------
// bap_pkg
// Shared types and constants of the block-average pixelate filter.
// ----------------------------------------------------------------------------
package bap_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned MaxBlock  = 64;

  localparam int unsigned ColW   = $clog2(MaxWidth);
  localparam int unsigned RowW   = $clog2(MaxHeight);
  localparam int unsigned OffW   = $clog2(MaxBlock);
  localparam int unsigned SumW   = 20;
  localparam int unsigned CountW = 2 * OffW + 1;
  localparam int unsigned CfgW   = 13;

  typedef enum logic [1:0] {
    CFG_BLOCK_SIZE   = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [7:0]      avg_red;
    logic [7:0]      avg_green;
    logic [7:0]      avg_blue;
    logic [RowW-1:0] block_row;
    logic [ColW-1:0] block_col;
    logic            last_block;
  } res_t;

  typedef struct packed {
    logic [SumW-1:0] red;
    logic [SumW-1:0] green;
    logic [SumW-1:0] blue;
  } sums_t;

  // Work handed from the accumulate stage to the divider.
  typedef struct packed {
    sums_t             sums;
    logic [CountW-1:0] count;
    logic [RowW-1:0]   block_row;
    logic [ColW-1:0]   block_col;
    logic              last_block;
  } div_job_t;

endpackage

FILE: rtl/bap_sum_mem.sv
// ----------------------------------------------------------------------------
// bap_sum_mem
// Per-block-column channel sums, one write and one registered read port.
// ----------------------------------------------------------------------------
module bap_sum_mem (
  input  logic                   clk_i,
  input  logic                   re_i,
  input  logic [bap_pkg::ColW-1:0] raddr_i,
  output bap_pkg::sums_t         rdata_o,
  input  logic                   we_i,
  input  logic [bap_pkg::ColW-1:0] waddr_i,
  input  bap_pkg::sums_t         wdata_i
);
  import bap_pkg::*;

  sums_t mem [MaxWidth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: rtl/bap_divider.sv
// ----------------------------------------------------------------------------
// bap_divider
// Bit-serial restoring divider: three channel sums by one pixel count.
// ----------------------------------------------------------------------------
module bap_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  bap_pkg::div_job_t job_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bap_pkg::res_t     out_data_o
);
  import bap_pkg::*;

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } div_state_e;

  div_state_e state_q, state_d;
  logic [2:0] step_q;
  sums_t      rem_q;
  logic [SumW-1:0] dvs_q;
  logic [7:0] q_r_q, q_g_q, q_b_q;
  logic [2:0] sat_q;
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] col_q;
  logic last_q;
  logic [SumW:0] lim;
  logic ge_r, ge_g, ge_b;

  assign free_o = (state_q == DIV_IDLE) || ((state_q == DIV_DONE) && out_ready_i);
  assign lim = {job_i.count, 8'd0};
  assign ge_r = rem_q.red >= dvs_q;
  assign ge_g = rem_q.green >= dvs_q;
  assign ge_b = rem_q.blue >= dvs_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DIV_IDLE: if (start_i) state_d = DIV_RUN;
      DIV_RUN:  if (step_q == 3'd0) state_d = DIV_DONE;
      DIV_DONE: begin
        if (out_ready_i) state_d = start_i ? DIV_RUN : DIV_IDLE;
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && free_o) begin
      rem_q  <= job_i.sums;
      dvs_q  <= SumW'({job_i.count, 7'd0});
      step_q <= 3'd7;
      sat_q  <= {{1'b0, job_i.sums.red} >= lim, {1'b0, job_i.sums.green} >= lim,
                 {1'b0, job_i.sums.blue} >= lim};
      row_q  <= job_i.block_row;
      col_q  <= job_i.block_col;
      last_q <= job_i.last_block;
    end else if (state_q == DIV_RUN) begin
      if (ge_r) rem_q.red <= rem_q.red - dvs_q;
      if (ge_g) rem_q.green <= rem_q.green - dvs_q;
      if (ge_b) rem_q.blue <= rem_q.blue - dvs_q;
      q_r_q  <= {q_r_q[6:0], ge_r};
      q_g_q  <= {q_g_q[6:0], ge_g};
      q_b_q  <= {q_b_q[6:0], ge_b};
      dvs_q  <= dvs_q >> 1;
      step_q <= step_q - 3'd1;
    end
  end

  assign out_valid_o          = (state_q == DIV_DONE);
  assign out_data_o.avg_red   = sat_q[2] ? 8'hFF : q_r_q;
  assign out_data_o.avg_green = sat_q[1] ? 8'hFF : q_g_q;
  assign out_data_o.avg_blue  = sat_q[0] ? 8'hFF : q_b_q;
  assign out_data_o.block_row = row_q;
  assign out_data_o.block_col = col_q;
  assign out_data_o.last_block = last_q;

endmodule

FILE: rtl/block_average_pixelate_top.sv
// ----------------------------------------------------------------------------
// block_average_pixelate_top
// Mosaic filter: per-block channel means of a raster RGB pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the input valid/ready channel, one transfer
// per pixel. Each block of block_size x block_size pixels (partial at the
// right and bottom edges) yields one result transfer carrying the truncated
// mean of each channel, the block's row and column, and a flag for the
// image's last block. Sums for the block columns of the current block row
// live in a 4096-entry memory with a registered read; a pixel reads its
// entry when accepted and writes the updated sum as it leaves the
// accumulate stage, with a forwarding register covering back-to-back
// pixels of the same block. Throughput is one pixel per cycle while no
// block completes. A completing block starts a bit-serial divider that
// loads the job and then develops the eight quotient bits; the result is
// registered and held until it transfers. A further completing pixel waits
// in the accumulate stage until the divider frees, so the divider takes
// one block at a time and block_size 1 gives the lowest result rate. If
// the receiver stalls, the result is held and the input backs up after one
// more completing pixel. Reset clears all counters and sets each
// configuration register to 1; the sum memory is not cleared, as every
// block's first pixel overwrites its entry. Configuration must be written
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module block_average_pixelate_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  bap_pkg::pix_t            in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output bap_pkg::res_t            out_data_o,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [bap_pkg::CfgW-1:0] cfg_data_i
);
  import bap_pkg::*;

  typedef struct packed {
    logic [ColW-1:0]   idx;
    logic              first;
    logic              emit;
    logic [CountW-1:0] count;
    logic [RowW-1:0]   block_row;
    logic              last_block;
    pix_t              pix;
  } s1_t;

  logic [6:0]      bs_q;
  logic [CfgW-1:0] w_q, h_q;
  logic [6:0]      bs;
  logic [CfgW-1:0] w, h;

  logic [ColW-1:0] pcol_q, bcol_q;
  logic [RowW-1:0] prow_q, brow_q;
  logic [OffW-1:0] ocol_q, orow_q;

  logic row_end, img_end, bc_end, br_end, accept;
  logic s1_valid_q, advance, div_free, start;
  s1_t  s1_q;
  sums_t rdata, base, new_sum, fwd_q;
  logic fwd_valid_q;
  logic [ColW-1:0] fwd_idx_q;
  div_job_t job;

  // Configuration registers, then their clamped working values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q <= 7'd1;
      w_q  <= CfgW'(1);
      h_q  <= CfgW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BLOCK_SIZE:   bs_q <= cfg_data_i[6:0];
        CFG_IMAGE_WIDTH:  w_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: h_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign bs = (bs_q == 7'd0) ? 7'd1 : (bs_q > 7'(MaxBlock)) ? 7'(MaxBlock) : bs_q;
  assign w = (w_q == '0) ? CfgW'(1) : (w_q > CfgW'(MaxWidth)) ? CfgW'(MaxWidth) : w_q;
  assign h = (h_q == '0) ? CfgW'(1) : (h_q > CfgW'(MaxHeight)) ? CfgW'(MaxHeight) : h_q;

  assign row_end = {1'b0, pcol_q} >= (w - CfgW'(1));
  assign img_end = {1'b0, prow_q} >= (h - CfgW'(1));
  assign bc_end  = row_end || ({1'b0, ocol_q} >= (bs - 7'd1));
  assign br_end  = img_end || ({1'b0, orow_q} >= (bs - 7'd1));

  // The accumulate stage moves on unless its block needs a busy divider.
  assign advance    = s1_valid_q && (!s1_q.emit || div_free);
  assign start      = s1_valid_q && s1_q.emit && div_free;
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  // Raster and block position counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcol_q <= '0;
      prow_q <= '0;
      ocol_q <= '0;
      orow_q <= '0;
      bcol_q <= '0;
      brow_q <= '0;
    end else if (accept) begin
      if (row_end) begin
        pcol_q <= '0;
        ocol_q <= '0;
        bcol_q <= '0;
        if (img_end) begin
          prow_q <= '0;
          orow_q <= '0;
          brow_q <= '0;
        end else begin
          prow_q <= prow_q + 1'b1;
          if (br_end) begin
            orow_q <= '0;
            brow_q <= brow_q + 1'b1;
          end else begin
            orow_q <= orow_q + 1'b1;
          end
        end
      end else begin
        pcol_q <= pcol_q + 1'b1;
        if (bc_end) begin
          ocol_q <= '0;
          bcol_q <= bcol_q + 1'b1;
        end else begin
          ocol_q <= ocol_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.idx        <= bcol_q;
      s1_q.first      <= (ocol_q == '0) && (orow_q == '0);
      s1_q.emit       <= bc_end && br_end;
      s1_q.count      <= CountW'({1'b0, ocol_q} + 7'd1) * CountW'({1'b0, orow_q} + 7'd1);
      s1_q.block_row  <= brow_q;
      s1_q.last_block <= row_end && img_end;
      s1_q.pix        <= in_data_i;
    end
  end

  bap_sum_mem u_mem (
    .clk_i   (clk_i),
    .re_i    (accept),
    .raddr_i (bcol_q),
    .rdata_o (rdata),
    .we_i    (advance),
    .waddr_i (s1_q.idx),
    .wdata_i (new_sum)
  );

  // The last written sum overrides a read that raced its write.
  assign base = (fwd_valid_q && (fwd_idx_q == s1_q.idx)) ? fwd_q : rdata;

  always_comb begin
    if (s1_q.first) begin
      new_sum.red   = SumW'(s1_q.pix.red);
      new_sum.green = SumW'(s1_q.pix.green);
      new_sum.blue  = SumW'(s1_q.pix.blue);
    end else begin
      new_sum.red   = base.red + SumW'(s1_q.pix.red);
      new_sum.green = base.green + SumW'(s1_q.pix.green);
      new_sum.blue  = base.blue + SumW'(s1_q.pix.blue);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (advance) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fwd_q     <= new_sum;
      fwd_idx_q <= s1_q.idx;
    end
  end

  assign job.sums       = new_sum;
  assign job.count      = s1_q.count;
  assign job.block_row  = s1_q.block_row;
  assign job.block_col  = s1_q.idx;
  assign job.last_block = s1_q.last_block;

  bap_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .job_i       (job),
    .free_o      (div_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A stalled completing pixel must still be waiting next cycle.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> s1_valid_q)
    else $error("accumulate stage dropped a stalled pixel");

  // No pixel is taken while the stage holds one that cannot move.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |-> !accept)
    else $error("pixel accepted over a stalled stage");

  // A divider start always comes with an update of the sum memory.
  a_start_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> advance)
    else $error("divider started without a sum write");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the block-average pixelate filter: random pixel
// streams over several image and block geometries, checked against a
// behavioral predictor of the per-block means.
// ----------------------------------------------------------------------------

class mosaic_scoreboard;
  int unsigned blk_size, img_w, img_h;
  int unsigned pix_col, pix_row, off_col, off_row, cur_bcol, cur_brow;
  int unsigned sum_r[4096], sum_g[4096], sum_b[4096];
  bap_pkg::res_t pending_means[$];
  int unsigned mismatches;
  int unsigned blocks_seen;

  function new();
    blk_size = 1; img_w = 1; img_h = 1;
    pix_col = 0; pix_row = 0; off_col = 0; off_row = 0; cur_bcol = 0; cur_brow = 0;
    mismatches = 0; blocks_seen = 0;
  endfunction

  function int unsigned clamp(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function void set_reg(bap_pkg::cfg_idx_e idx, int unsigned value);
    case (idx)
      bap_pkg::CFG_BLOCK_SIZE:   blk_size = value & 'h7F;
      bap_pkg::CFG_IMAGE_WIDTH:  img_w = value & 'h1FFF;
      bap_pkg::CFG_IMAGE_HEIGHT: img_h = value & 'h1FFF;
      default: ;
    endcase
  endfunction

  function int unsigned mean8(int unsigned s, int unsigned n);
    int unsigned q;
    q = s / n;
    return (q > 255) ? 255 : q;
  endfunction

  // Advance the raster position for one accepted pixel and queue a block mean
  // when it completes a block.
  function void note_pixel(bap_pkg::pix_t px);
    int unsigned bs, w, h, idx;
    bit row_end, img_end, bc_end, br_end;
    bap_pkg::res_t r;
    bs = clamp(blk_size, bap_pkg::MaxBlock);
    w = clamp(img_w, bap_pkg::MaxWidth);
    h = clamp(img_h, bap_pkg::MaxHeight);
    idx = cur_bcol;
    row_end = pix_col >= w - 1;
    img_end = pix_row >= h - 1;
    bc_end = row_end || off_col >= bs - 1;
    br_end = img_end || off_row >= bs - 1;
    if (idx < bap_pkg::MaxWidth) begin
      if (off_col == 0 && off_row == 0) begin
        sum_r[idx] = px.red; sum_g[idx] = px.green; sum_b[idx] = px.blue;
      end else begin
        sum_r[idx] = (sum_r[idx] + px.red) & 'hFFFFF;
        sum_g[idx] = (sum_g[idx] + px.green) & 'hFFFFF;
        sum_b[idx] = (sum_b[idx] + px.blue) & 'hFFFFF;
      end
      if (bc_end && br_end) begin
        r.avg_red = mean8(sum_r[idx], (off_col + 1) * (off_row + 1));
        r.avg_green = mean8(sum_g[idx], (off_col + 1) * (off_row + 1));
        r.avg_blue = mean8(sum_b[idx], (off_col + 1) * (off_row + 1));
        r.block_row = cur_brow[11:0];
        r.block_col = cur_bcol[11:0];
        r.last_block = row_end && img_end;
        pending_means.insert(pending_means.size(), r);
      end
    end
    if (row_end) begin
      pix_col = 0; off_col = 0; cur_bcol = 0;
      if (img_end) begin
        pix_row = 0; off_row = 0; cur_brow = 0;
      end else begin
        pix_row++;
        if (br_end) begin
          off_row = 0; cur_brow++;
        end else begin
          off_row++;
        end
      end
    end else begin
      pix_col++;
      if (bc_end) begin
        off_col = 0; cur_bcol++;
      end else begin
        off_col++;
      end
    end
  endfunction

  function void check_mean(bap_pkg::res_t got);
    bap_pkg::res_t exp_r;
    blocks_seen++;
    if (pending_means.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_r = pending_means.pop_front();
    if (got.avg_red !== exp_r.avg_red || got.avg_green !== exp_r.avg_green ||
        got.avg_blue !== exp_r.avg_blue || got.block_row !== exp_r.block_row ||
        got.block_col !== exp_r.block_col || got.last_block !== exp_r.last_block) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp r%0d g%0d b%0d row%0d col%0d last%0d, got r%0d g%0d b%0d row%0d col%0d last%0d",
                 exp_r.avg_red, exp_r.avg_green, exp_r.avg_blue, exp_r.block_row,
                 exp_r.block_col, exp_r.last_block, got.avg_red, got.avg_green,
                 got.avg_blue, got.block_row, got.block_col, got.last_block);
    end
  endfunction
endclass

module testbench;
  import bap_pkg::*;

  localparam int unsigned StallLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pix_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  res_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [CfgW-1:0] cfg_data = '0;

  mosaic_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  int unsigned pixels_sent = 0;
  bit stim_done = 1'b0;
  bit rx_enable = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  block_average_pixelate_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Transfers are sampled at the rising edge; the scoreboard sees them there.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_pixel(in_data);
      if (out_valid && out_ready) sb.check_mean(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || !in_valid && stim_done &&
          sb.pending_means.size() == 0)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no transfer for %0d cycles", StallLimit);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Receiver: random stalls, with long stretches of steady readiness too.
  initial begin
    int unsigned g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      g = 0;
      if (rx_enable && $urandom_range(0, 3) == 0) g = gap_len();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value[CfgW-1:0];
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sends one pixel and waits for its transfer; idle gaps come beforehand.
  // Valid stays high between back-to-back pixels; a gap or drain() drops it.
  task automatic send_pixel(pix_t px, bit allow_gap);
    int unsigned g;
    g = 0;
    if (allow_gap) g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_means.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  // One complete image under the given geometry; returns once its results have drained.
  task automatic run_image(int unsigned bs, int unsigned w, int unsigned h, int mode);
    pix_t px;
    bit burst;
    write_reg(CFG_BLOCK_SIZE, bs);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    burst = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < w * h; i++) begin
      case (mode)
        0: px = '0;
        1: px = '1;
        default: px = pix_t'(24'($urandom));
      endcase
      send_pixel(px, !burst);
    end
    drain();
  endtask

  initial begin
    int unsigned bs, w, h;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // Reset geometry: each pixel is its own block and image.
    send_pixel(pix_t'(24'hFF00A5), 1'b0);
    send_pixel(pix_t'(24'h5AFF00), 1'b0);
    drain();
    // Directed: all-zero and all-one blocks, partial edge blocks.
    run_image(2, 3, 3, 0);
    run_image(2, 3, 3, 1);
    run_image(4, 5, 2, 2);
    // Extremes: a single tall column, one wide row, largest block size.
    run_image(64, 1, 6, 1);
    run_image(1, 200, 1, 2);
    run_image(64, 70, 1, 2);
    run_image(3, 1, 1, 2);
    // Random geometries, small images for many results.
    while (pixels_sent < 440) begin
      bs = $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) bs = $urandom_range(7, 64);
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      run_image(bs, w, h, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : 2);
    end
    // A tall single column that is one partial block of the largest size.
    run_image(64, 1, 40, 2);
    stim_done = 1'b1;
    drain();
    $display("covered %0d pixels over many geometries and %0d block results",
             pixels_sent, sb.blocks_seen);
    if (sb.mismatches == 0 && sb.pending_means.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches,
               sb.pending_means.size());
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule

FILE: block_average_pixelate_top.f
rtl/bap_pkg.sv
rtl/bap_sum_mem.sv
rtl/bap_divider.sv
rtl/block_average_pixelate_top.sv
tb/sv/testbench.sv
